[rtl/core/sbck_pkg.sv]
// shared types, constants and helper functions for the sprite blitter
package sbck_pkg;

    localparam int unsigned DIM_BITS_DEF = 12;
    localparam int unsigned COLOR_W      = 32;
    localparam int unsigned ADDR_W       = 26;
    localparam int unsigned POS_W        = 16;
    localparam int unsigned SIZE_W       = 12;
    localparam int unsigned BPP_W        = 6;
    localparam int unsigned NBYTES_W     = 3;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [COLOR_W-1:0] KEY_COLOR = 32'hff00_0000;

    localparam logic [POS_W-1:0]  RST_X_ORIGIN = 16'd0;
    localparam logic [POS_W-1:0]  RST_Y_ORIGIN = 16'd0;
    localparam logic [SIZE_W-1:0] RST_WIDTH    = 12'd1;
    localparam logic [SIZE_W-1:0] RST_HEIGHT   = 12'd1;
    localparam logic [SIZE_W-1:0] RST_XRES     = 12'd1024;
    localparam logic [SIZE_W-1:0] RST_YRES     = 12'd768;
    localparam logic [BPP_W-1:0]  RST_BPP      = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN     = 3'd0,
        CFG_Y_ORIGIN     = 3'd1,
        CFG_SPRITE_WIDTH = 3'd2,
        CFG_SPRITE_HEIGHT= 3'd3,
        CFG_MIRROR       = 3'd4,
        CFG_X_RES        = 3'd5,
        CFG_Y_RES        = 3'd6,
        CFG_BPP          = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_prod;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [NBYTES_W-1:0] bytes_for_depth(input logic [BPP_W-1:0] bpp);
        logic [BPP_W:0] s;
        logic [3:0]     n;
        begin
            s = {1'b0, bpp} + 7'd7;
            n = s[BPP_W:3];
            if (n == 4'd0) begin
                n = 4'd1;
            end else if (n > 4'd4) begin
                n = 4'd4;
            end
            return n[NBYTES_W-1:0];
        end
    endfunction

    function automatic logic [COLOR_W-1:0] mask_color(input logic [COLOR_W-1:0] c,
                                                      input logic [BPP_W-1:0] bpp);
        logic [COLOR_W-1:0] m;
        begin
            if (bpp >= 6'd32) begin
                m = '1;
            end else begin
                m = (32'h1 << bpp) - 32'h1;
            end
            return c & m;
        end
    endfunction

endpackage

[rtl/core/sbck_pix_if.sv]
// input pixel channel
interface sbck_pix_if;
    logic                            valid;
    logic                            ready;
    logic [sbck_pkg::COLOR_W-1:0]    pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

[rtl/core/sbck_wr_if.sv]
// framebuffer write result channel
interface sbck_wr_if;
    logic                            valid;
    logic                            ready;
    logic                            write_enable;
    logic [sbck_pkg::ADDR_W-1:0]     write_address;
    logic [sbck_pkg::COLOR_W-1:0]    write_data;
    logic [sbck_pkg::NBYTES_W-1:0]   byte_count;
    logic                            out_of_range;
    logic                            aborted;
    logic                            sprite_done;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, output byte_count, output out_of_range,
                    output aborted, output sprite_done, input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_data, input byte_count, input out_of_range,
                    input aborted, input sprite_done, output ready);
endinterface

[rtl/core/sbck_ctrl.sv]
// controller state machine: accept, row multiply, address scale and output load
module sbck_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  sbck_pkg::t_dp_status   i_sts,
    output sbck_pkg::t_ctrl_cmd    o_cmd
);

    sbck_pkg::t_state r_state;
    sbck_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbck_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            sbck_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sbck_pkg::ST_MUL;
                end
            end
            sbck_pkg::ST_MUL: begin
                o_cmd.load_prod = 1'b1;
                n_state         = sbck_pkg::ST_ADDR;
            end
            sbck_pkg::ST_ADDR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = sbck_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbck_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/sbck_datapath.sv]
// datapath: config registers, sprite counters, screen check, address and output register
module sbck_datapath #(
    parameter int unsigned DIM_BITS = sbck_pkg::DIM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sbck_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbck_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [sbck_pkg::COLOR_W-1:0]        i_pixel_color,
    input  sbck_pkg::t_ctrl_cmd                 i_cmd,
    output sbck_pkg::t_dp_status                o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_write_enable,
    output logic [sbck_pkg::ADDR_W-1:0]         o_write_address,
    output logic [sbck_pkg::COLOR_W-1:0]        o_write_data,
    output logic [sbck_pkg::NBYTES_W-1:0]       o_byte_count,
    output logic                                o_out_of_range,
    output logic                                o_aborted,
    output logic                                o_sprite_done
);

    localparam int unsigned EXT_W = sbck_pkg::POS_W + 1;

    // configuration
    logic [sbck_pkg::POS_W-1:0]   r_x_origin;
    logic [sbck_pkg::POS_W-1:0]   r_y_origin;
    logic [sbck_pkg::SIZE_W-1:0]  r_sprite_width;
    logic [sbck_pkg::SIZE_W-1:0]  r_sprite_height;
    logic                         r_mirror;
    logic [sbck_pkg::SIZE_W-1:0]  r_x_res;
    logic [sbck_pkg::SIZE_W-1:0]  r_y_res;
    logic [sbck_pkg::BPP_W-1:0]   r_bpp;

    // sprite walk state
    logic [DIM_BITS-1:0]          r_col;
    logic [DIM_BITS-1:0]          r_row;
    logic                         r_failed;

    // per-beat work registers
    logic [sbck_pkg::POS_W-1:0]   r_dx;
    logic [sbck_pkg::POS_W-1:0]   r_dy;
    logic [sbck_pkg::COLOR_W-1:0] r_data;
    logic                         r_we;
    logic                         r_oor;
    logic                         r_ab;
    logic                         r_done;
    logic [sbck_pkg::ADDR_W-1:0]  r_prod;

    // output register
    logic                         r_out_valid;
    logic                         r_o_we;
    logic [sbck_pkg::ADDR_W-1:0]  r_o_addr;
    logic [sbck_pkg::COLOR_W-1:0] r_o_data;
    logic [sbck_pkg::NBYTES_W-1:0] r_o_nbytes;
    logic                         r_o_oor;
    logic                         r_o_ab;
    logic                         r_o_done;

    logic [EXT_W-1:0]             w_wm1;
    logic [EXT_W-1:0]             w_hm1;
    logic [DIM_BITS-1:0]          w_last_col;
    logic [DIM_BITS-1:0]          w_last_row;
    logic [DIM_BITS-1:0]          w_col_off;
    logic [sbck_pkg::POS_W-1:0]   w_dx;
    logic [sbck_pkg::POS_W-1:0]   w_dy;
    logic                         w_key;
    logic                         w_off;
    logic                         w_we;
    logic                         w_failed_now;
    logic                         w_col_end;
    logic                         w_row_end;
    logic [sbck_pkg::NBYTES_W-1:0] w_nbytes;
    logic [sbck_pkg::ADDR_W-1:0]  w_lin;
    logic [sbck_pkg::ADDR_W-1:0]  w_addr;

    always_comb begin
        w_wm1        = EXT_W'(r_sprite_width) - EXT_W'(1);
        w_hm1        = EXT_W'(r_sprite_height) - EXT_W'(1);
        w_last_col   = w_wm1[DIM_BITS-1:0];
        w_last_row   = w_hm1[DIM_BITS-1:0];
        w_col_off    = r_mirror ? (w_last_col - r_col) : r_col;
        w_dx         = r_x_origin + sbck_pkg::POS_W'(w_col_off);
        w_dy         = r_y_origin + sbck_pkg::POS_W'(r_row);
        w_key        = (i_pixel_color == sbck_pkg::KEY_COLOR);
        w_off        = (w_dx >= sbck_pkg::POS_W'(r_x_res)) ||
                       (w_dy >= sbck_pkg::POS_W'(r_y_res));
        w_we         = !w_key && !w_off && !r_failed;
        w_failed_now = r_failed || (!w_key && w_off);
        w_col_end    = (r_col == w_last_col);
        w_row_end    = (r_row == w_last_row);
        w_nbytes     = sbck_pkg::bytes_for_depth(r_bpp);
        w_lin        = r_prod + sbck_pkg::ADDR_W'(r_dx);
        w_addr       = r_we ? sbck_pkg::ADDR_W'(w_lin * w_nbytes) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin      <= sbck_pkg::RST_X_ORIGIN;
            r_y_origin      <= sbck_pkg::RST_Y_ORIGIN;
            r_sprite_width  <= sbck_pkg::RST_WIDTH;
            r_sprite_height <= sbck_pkg::RST_HEIGHT;
            r_mirror        <= 1'b0;
            r_x_res         <= sbck_pkg::RST_XRES;
            r_y_res         <= sbck_pkg::RST_YRES;
            r_bpp           <= sbck_pkg::RST_BPP;
        end else if (i_cfg_we) begin
            unique case (sbck_pkg::t_cfg_idx'(i_cfg_idx))
                sbck_pkg::CFG_X_ORIGIN:      r_x_origin      <= i_cfg_data;
                sbck_pkg::CFG_Y_ORIGIN:      r_y_origin      <= i_cfg_data;
                sbck_pkg::CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[sbck_pkg::SIZE_W-1:0];
                sbck_pkg::CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[sbck_pkg::SIZE_W-1:0];
                sbck_pkg::CFG_MIRROR:        r_mirror        <= i_cfg_data[0];
                sbck_pkg::CFG_X_RES:         r_x_res         <= i_cfg_data[sbck_pkg::SIZE_W-1:0];
                sbck_pkg::CFG_Y_RES:         r_y_res         <= i_cfg_data[sbck_pkg::SIZE_W-1:0];
                sbck_pkg::CFG_BPP:           r_bpp           <= i_cfg_data[sbck_pkg::BPP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_failed <= 1'b0;
        end else if (i_cmd.accept) begin
            if (w_col_end) begin
                r_col <= '0;
                if (w_row_end) begin
                    r_row    <= '0;
                    r_failed <= 1'b0;
                end else begin
                    r_row    <= r_row + {{(DIM_BITS-1){1'b0}}, 1'b1};
                    r_failed <= w_failed_now;
                end
            end else begin
                r_col    <= r_col + {{(DIM_BITS-1){1'b0}}, 1'b1};
                r_failed <= w_failed_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_we   <= w_we;
            r_data <= w_we ? sbck_pkg::mask_color(i_pixel_color, r_bpp) : '0;
            r_oor  <= !w_key && w_off;
            r_ab   <= w_failed_now;
            r_done <= w_col_end && w_row_end;
        end
        if (i_cmd.load_prod) begin
            r_prod <= sbck_pkg::ADDR_W'(r_dy) * sbck_pkg::ADDR_W'(r_x_res);
        end
        if (i_cmd.load_out) begin
            r_o_we     <= r_we;
            r_o_addr   <= w_addr;
            r_o_data   <= r_data;
            r_o_nbytes <= w_nbytes;
            r_o_oor    <= r_oor;
            r_o_ab     <= r_ab;
            r_o_done   <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_write_enable  = r_o_we;
    assign o_write_address = r_o_addr;
    assign o_write_data    = r_o_data;
    assign o_byte_count    = r_o_nbytes;
    assign o_out_of_range  = r_o_oor;
    assign o_aborted       = r_o_ab;
    assign o_sprite_done   = r_o_done;

endmodule

[rtl/core/sprite_blit_color_key_unit.sv]
// Sprite blitter with color key and horizontal mirror. Takes one 32-bit color
// beat at a time in stored row-major order and returns one write beat for each.
// Each pixel passes the accept state (counters, destination and screen check),
// the row multiply state for y * x_resolution, and the address state, which
// adds x and scales by the byte count into the output register once that is
// free. The output register holds a result while the next pixel is already
// accepted; a new pixel is taken only after the last one is loaded out.
// Configuration writes take effect on the next clock and are meant for idle time.
module sprite_blit_color_key_unit #(
    parameter int unsigned DIM_BITS = sbck_pkg::DIM_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbck_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbck_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sbck_pix_if.sink                          i_pix,
    sbck_wr_if.source                         o_wr
);

    sbck_pkg::t_ctrl_cmd  w_cmd;
    sbck_pkg::t_dp_status w_sts;
    logic                 w_in_ready;

    sbck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_pix.ready = w_in_ready;

    sbck_datapath #(
        .DIM_BITS (DIM_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_color   (i_pix.pixel_color),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (o_wr.ready),
        .o_out_valid     (o_wr.valid),
        .o_write_enable  (o_wr.write_enable),
        .o_write_address (o_wr.write_address),
        .o_write_data    (o_wr.write_data),
        .o_byte_count    (o_wr.byte_count),
        .o_out_of_range  (o_wr.out_of_range),
        .o_aborted       (o_wr.aborted),
        .o_sprite_done   (o_wr.sprite_done)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("second beat taken while a pixel is in flight");

    a_mul_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> w_cmd.load_prod)
        else $error("row multiply did not follow an accepted beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("output register loaded while holding an untaken beat");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && o_wr.write_enable) |-> (!o_wr.out_of_range && !o_wr.aborted))
        else $error("write issued for an off-screen or aborted pixel");
`endif

endmodule
